/* design/ppt_pkg.sv */
// Shared types and constants for the projective point transform.
`default_nettype none
package ppt_pkg;

  // Fixed field and register widths
  localparam int COORD_W   = 32;
  localparam int PAIR_W    = 64;
  localparam int NUM_PAIRS = 8;
  localparam int NUM_COEF  = 16;
  localparam int CFG_IDX_W = 8;

  // Pipeline depths of the two sections
  localparam int MAC_LAT = 2;
  localparam int DIV_LAT = 35;

  // One input item: the point
  typedef struct packed {
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
  } in_t;

  // One result item
  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      zero_w_fault;
    logic                      saturated;
  } out_t;

endpackage
`default_nettype wire

/* design/ppt_mac.sv */
// Matrix-vector section: products in the first stage, row sums in the second.
`default_nettype none
module ppt_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  ppt_pkg::in_t                           item_i,
  input  logic signed [ppt_pkg::COORD_W-1:0]     coef_i [ppt_pkg::NUM_COEF],
  output logic signed [65-FRAC_BITS:0]           row_o [4]
);
  import ppt_pkg::*;

  localparam int SUM_W = 66 - FRAC_BITS;

  logic signed [COORD_W-1:0]   crd [3];
  logic signed [2*COORD_W-1:0] prod_q [12];
  logic signed [COORD_W-1:0]   trn_q [4];
  logic signed [SUM_W-1:0]     row_q [4];

  assign crd[0] = item_i.in_x;
  assign crd[1] = item_i.in_y;
  assign crd[2] = item_i.in_z;

  // Stage 1: twelve exact products, translation column alongside
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[3*r+c] <= coef_i[r+4*c] * crd[c];
        end
        trn_q[r] <= coef_i[r+12];
      end
    end
  end

  // Stage 2: floor shift of each product, then exact row sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 4; r++) begin
        row_q[r] <= SUM_W'(prod_q[3*r]   >>> FRAC_BITS)
                  + SUM_W'(prod_q[3*r+1] >>> FRAC_BITS)
                  + SUM_W'(prod_q[3*r+2] >>> FRAC_BITS)
                  + SUM_W'(trn_q[r]);
      end
    end
  end

  assign row_o = row_q;

endmodule
`default_nettype wire

/* design/ppt_div.sv */
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit a stage.
`default_nettype none
module ppt_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [65-FRAC_BITS:0]       num_i,
  input  logic signed [65-FRAC_BITS:0]       den_i,
  output logic signed [ppt_pkg::COORD_W-1:0] quo_o,
  output logic                               sat_o
);
  import ppt_pkg::*;

  localparam int SUM_W = 66 - FRAC_BITS;
  localparam int RW    = SUM_W + COORD_W;

  logic [SUM_W-1:0]   a_q, d_q;
  logic               neg_q;
  logic [RW-1:0]      rem_q [COORD_W];
  logic [SUM_W-1:0]   dv_q  [COORD_W];
  logic [COORD_W-1:0] qt_q  [1:COORD_W];
  logic [COORD_W:0]   ng_q;
  logic [COORD_W:0]   st_q;
  logic [COORD_W:0]   mag;
  logic               neg_fin;
  logic signed [COORD_W-1:0] res_q;
  logic               sat_q;

  // Stage A: magnitudes and result sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= num_i[SUM_W-1] ? SUM_W'(-num_i) : SUM_W'(num_i);
      d_q   <= den_i[SUM_W-1] ? SUM_W'(-den_i) : SUM_W'(den_i);
      neg_q <= num_i[SUM_W-1] ^ den_i[SUM_W-1];
    end
  end

  // Stage B: overflow when the integer quotient already needs the top bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0]  <= (RW'(a_q) << FRAC_BITS) >= (RW'(d_q) << COORD_W);
      rem_q[0] <= RW'(a_q) << FRAC_BITS;
      dv_q[0]  <= d_q;
      ng_q[0]  <= neg_q && (a_q != '0);
    end
  end

  // Quotient stages, most significant bit first
  for (genvar k = 0; k < COORD_W; k++) begin : g_bit
    logic [RW-1:0] sub;
    logic          ge;
    assign sub = RW'(dv_q[k]) << (COORD_W - 1 - k);
    assign ge  = rem_q[k] >= sub;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ng_q[k+1] <= ng_q[k];
        st_q[k+1] <= st_q[k];
      end
    end
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en_i) qt_q[1] <= COORD_W'(ge);
      end
    end else begin : g_rest
      always_ff @(posedge clk_i) begin
        if (en_i) qt_q[k+1] <= {qt_q[k][COORD_W-2:0], ge};
      end
    end
    if (k < COORD_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= ge ? rem_q[k] - sub : rem_q[k];
          dv_q[k+1]  <= dv_q[k];
        end
      end
    end
  end

  // Final stage: sign and clamp to 32 bits
  assign mag     = st_q[COORD_W] ? ((COORD_W+1)'(1) << COORD_W)
                                 : {1'b0, qt_q[COORD_W]};
  assign neg_fin = ng_q[COORD_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (neg_fin) begin
        if (mag > ((COORD_W+1)'(1) << (COORD_W-1))) begin
          res_q <= {1'b1, {(COORD_W-1){1'b0}}};
          sat_q <= 1'b1;
        end else begin
          res_q <= -mag[COORD_W-1:0];
          sat_q <= 1'b0;
        end
      end else if (mag[COORD_W] || mag[COORD_W-1]) begin
        res_q <= {1'b0, {(COORD_W-1){1'b1}}};
        sat_q <= 1'b1;
      end else begin
        res_q <= mag[COORD_W-1:0];
        sat_q <= 1'b0;
      end
    end
  end

  assign quo_o = res_q;
  assign sat_o = sat_q;

endmodule
`default_nettype wire

/* design/projective_point_transform_core.sv */
// An accepted item passes through the multiply-add section and then the divide section to its result.
// Throughput: one item per cycle; three dividers with 32 bit-per-stage quotient stages run side by side.
// The whole pipeline holds while a result waits on a stalled output; bubbles are kept.
// Reset clears the valid line and loads the identity matrix into the coefficient registers.
`default_nettype none
module projective_point_transform_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  ppt_pkg::in_t                       in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output ppt_pkg::out_t                      out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ppt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ppt_pkg::PAIR_W-1:0]         cfg_data_i
);
  import ppt_pkg::*;

  localparam int SUM_W = 66 - FRAC_BITS;
  localparam int TOT   = MAC_LAT + DIV_LAT;
  localparam logic [COORD_W-1:0] ONE = COORD_W'(64'd1 << FRAC_BITS);

  logic [PAIR_W-1:0]         pair_q [NUM_PAIRS];
  logic signed [COORD_W-1:0] coef [NUM_COEF];
  logic signed [SUM_W-1:0]   row [4];
  logic signed [COORD_W-1:0] quo [3];
  logic [2:0]                sat;
  logic [TOT-1:0]            vld_q;
  logic [TOT-1:MAC_LAT]      flt_q;
  logic                      adv;

  // Coefficient registers, identity after reset
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PAIRS; i++) begin
        pair_q[i] <= {(((2*i+1) % 5) == 0) ? ONE : '0,
                      (((2*i) % 5) == 0)   ? ONE : '0};
      end
    end else if (cfg_valid_i) begin
      for (int i = 0; i < NUM_PAIRS; i++) begin
        if (cfg_index_i == CFG_IDX_W'(i)) pair_q[i] <= cfg_data_i;
      end
    end
  end

  // Unpack element pairs, lower index in the low half
  for (genvar k = 0; k < NUM_COEF; k++) begin : g_coef
    assign coef[k] = pair_q[k>>1][COORD_W*(k&1) +: COORD_W];
  end

  // Pipeline moves unless a finished result is held up
  assign adv        = !(vld_q[TOT-1] && out_stall_i);
  assign in_stall_o = !adv;

  ppt_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk_i  (clk_i),
    .en_i   (adv),
    .item_i (in_data_i),
    .coef_i (coef),
    .row_o  (row)
  );

  for (genvar j = 0; j < 3; j++) begin : g_div
    ppt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (row[j]),
      .den_i (row[3]),
      .quo_o (quo[j]),
      .sat_o (sat[j])
    );
  end

  // Valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[TOT-2:0], in_valid_i};
    end
  end

  // Zero denominator flag rides alongside the dividers
  always_ff @(posedge clk_i) begin
    if (adv) flt_q <= {flt_q[TOT-2:MAC_LAT], row[3] == '0};
  end

  // Result item
  always_comb begin
    out_valid_o = vld_q[TOT-1];
    if (flt_q[TOT-1]) begin
      out_data_o.out_x        = '0;
      out_data_o.out_y        = '0;
      out_data_o.out_z        = '0;
      out_data_o.zero_w_fault = 1'b1;
      out_data_o.saturated    = 1'b0;
    end else begin
      out_data_o.out_x        = quo[0];
      out_data_o.out_y        = quo[1];
      out_data_o.out_z        = quo[2];
      out_data_o.zero_w_fault = 1'b0;
      out_data_o.saturated    = |sat;
    end
  end

  // Checks
  a_stall_only_on_blocked_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output not blocked");

  a_accept_enters_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted item lost at pipeline entry");

  a_held_result_stays : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(vld_q)))
    else $error("pipeline moved while result was held");

  a_fault_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.zero_w_fault) |-> !out_data_o.saturated)
    else $error("fault and saturation both raised");

endmodule
`default_nettype wire
